/* design/rgb444_to_hue_sat_lum_defines.svh */
// assertion macros shared by the rgb444 to hue/sat/lum converter
// expects signals clk and rst_n in the scope where a macro is used
`ifndef RGB444_TO_HUE_SAT_LUM_DEFINES_SVH
`define RGB444_TO_HUE_SAT_LUM_DEFINES_SVH

// check that is switched off while reset is held
`define RGBHSL_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define RGBHSL_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rgbhsl_pkg.sv */
// types and constants for the rgb444 to hue/sat/lum converter
// no dependencies
package rgbhsl_pkg;

  localparam int NIB_W      = 4;
  localparam int NIB_LEVELS = 1 << NIB_W;
  localparam int COLOR_W    = 3 * NIB_W;
  localparam int FIELD_W    = 16;
  localparam int PART_W     = 13;
  localparam int HRAW_W     = 15;
  localparam int PROD_W     = 26;
  localparam int RECIP_W    = 27;
  localparam int RECIP_SH   = 36;

  localparam int SAT_SCALE  = 1 << 16;
  localparam int PART_SCALE = 1 << 12;
  localparam int SAT_LIMIT  = 16'hFFFF;

  localparam logic signed [FIELD_W-1:0] HUE_OFF_GRN = 16'sh2000;
  localparam logic signed [FIELD_W-1:0] HUE_OFF_BLU = 16'sh4000;
  localparam logic signed [FIELD_W-1:0] HUE_WRAP    = 16'sh6000;

  localparam logic [PROD_W-1:0]  HUE_SCALE = PROD_W'(2667);
  // ceil(2**RECIP_SH / 1000), exact floor division for products below 2**26
  localparam logic [RECIP_W-1:0] HUE_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd999) / 64'd1000);

  typedef logic [NIB_W-1:0]   nib_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [PART_W-1:0]  part_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } hue_sec_t;

endpackage

/* design/rgbhsl_in_if.sv */
// input channel of the rgb444 to hue/sat/lum converter
// depends on rgbhsl_pkg
interface rgbhsl_in_if;
  logic                  valid;
  logic                  ready;
  rgbhsl_pkg::color_t    packed_color;

  modport source (output valid, output packed_color, input ready);
  modport sink   (input valid, input packed_color, output ready);
endinterface

/* design/rgbhsl_out_if.sv */
// result channel of the rgb444 to hue/sat/lum converter
// depends on rgbhsl_pkg
interface rgbhsl_out_if;
  logic                  valid;
  logic                  ready;
  rgbhsl_pkg::field_t    hue;
  rgbhsl_pkg::field_t    saturation;
  rgbhsl_pkg::field_t    luminance;

  modport source (output valid, output hue, output saturation, output luminance,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input luminance,
                  output ready);
endinterface

/* design/rgb444_to_hue_sat_lum.sv */
// rgb444 to hue/saturation/luminance converter, five register stages
// depends on rgbhsl_pkg, rgbhsl_in_if, rgbhsl_out_if and the defines header
//
// usage:
//   in_chan carries one 12-bit color word (red 11:8, green 7:4, blue 3:0),
//   out_chan returns hue, saturation and luminance, one word per input word,
//   in input order. both channels use valid/ready; a word moves on a clock
//   edge where both are high.
//   a new word is accepted every cycle while the receiver keeps ready high,
//   so throughput is one word per clock.
//   stage 1 finds max, min and spread, stage 2 reads the quotient tables,
//   stage 3 forms and wraps the raw hue, stage 4 multiplies by 2667 and
//   stage 5 divides by 1000 through a reciprocal multiply.
//   when out_chan.ready is low the pipeline compacts: empty stages still
//   fill, and in_chan.ready drops only when every stage holds a word.
//   synchronous reset empties all stages; words in flight are dropped.
`include "rgb444_to_hue_sat_lum_defines.svh"

module rgb444_to_hue_sat_lum (
  input  logic                clk,
  input  logic                rst_n,
  rgbhsl_in_if.sink           in_chan,
  rgbhsl_out_if.source        out_chan
);

  // constant quotient tables
  rgbhsl_pkg::field_t sat_lut  [rgbhsl_pkg::NIB_LEVELS][rgbhsl_pkg::NIB_LEVELS];
  rgbhsl_pkg::part_t  part_lut [rgbhsl_pkg::NIB_LEVELS][rgbhsl_pkg::NIB_LEVELS];

  for (genvar m = 0; m < rgbhsl_pkg::NIB_LEVELS; m++) begin : g_row
    for (genvar s = 0; s < rgbhsl_pkg::NIB_LEVELS; s++) begin : g_col
      localparam int SatQ  = (m == 0) ? 0 :
                             (s * rgbhsl_pkg::SAT_SCALE) / ((m == 0) ? 1 : m);
      localparam int PartQ = (m * rgbhsl_pkg::PART_SCALE) / ((s == 0) ? 1 : s);
      assign sat_lut[m][s]  = (SatQ > rgbhsl_pkg::SAT_LIMIT) ?
                              rgbhsl_pkg::FIELD_W'(rgbhsl_pkg::SAT_LIMIT) :
                              rgbhsl_pkg::FIELD_W'(SatQ);
      assign part_lut[m][s] = rgbhsl_pkg::PART_W'(PartQ);
    end
  end

  // stage valid and advance
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !s5_v_r || out_chan.ready;
  assign adv4 = !s4_v_r || adv5;
  assign adv3 = !s3_v_r || adv4;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;

  assign in_chan.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_chan.valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
      if (adv4) s4_v_r <= s3_v_r;
      if (adv5) s5_v_r <= s4_v_r;
    end
  end

  // stage 1: max, min, spread, sector
  rgbhsl_pkg::nib_t     red_nxt, grn_nxt, blu_nxt;
  rgbhsl_pkg::nib_t     max_rg, min_rg, max_nxt, min_nxt, spr_nxt;
  rgbhsl_pkg::hue_sec_t sec_nxt;

  rgbhsl_pkg::nib_t     s1_red_r, s1_grn_r, s1_blu_r, s1_max_r, s1_spr_r;
  rgbhsl_pkg::hue_sec_t s1_sec_r;

  always_comb begin
    red_nxt = in_chan.packed_color[11:8];
    grn_nxt = in_chan.packed_color[7:4];
    blu_nxt = in_chan.packed_color[3:0];
    max_rg  = (red_nxt > grn_nxt) ? red_nxt : grn_nxt;
    min_rg  = (red_nxt < grn_nxt) ? red_nxt : grn_nxt;
    max_nxt = (blu_nxt > max_rg) ? blu_nxt : max_rg;
    min_nxt = (blu_nxt < min_rg) ? blu_nxt : min_rg;
    spr_nxt = max_nxt - min_nxt;
    if (red_nxt == max_nxt) begin
      sec_nxt = rgbhsl_pkg::SEC_RED;
    end else if (grn_nxt == max_nxt) begin
      sec_nxt = rgbhsl_pkg::SEC_GREEN;
    end else begin
      sec_nxt = rgbhsl_pkg::SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_red_r <= red_nxt;
      s1_grn_r <= grn_nxt;
      s1_blu_r <= blu_nxt;
      s1_max_r <= max_nxt;
      s1_spr_r <= spr_nxt;
      s1_sec_r <= sec_nxt;
    end
  end

  // stage 2: table reads
  rgbhsl_pkg::nib_t     d_red, d_grn, d_blu;
  rgbhsl_pkg::part_t    s2_rp_r, s2_gp_r, s2_bp_r;
  rgbhsl_pkg::field_t   s2_sat_r;
  rgbhsl_pkg::nib_t     s2_max_r;
  rgbhsl_pkg::hue_sec_t s2_sec_r;

  assign d_red = s1_max_r - s1_red_r;
  assign d_grn = s1_max_r - s1_grn_r;
  assign d_blu = s1_max_r - s1_blu_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_rp_r  <= part_lut[d_red][s1_spr_r];
      s2_gp_r  <= part_lut[d_grn][s1_spr_r];
      s2_bp_r  <= part_lut[d_blu][s1_spr_r];
      s2_sat_r <= sat_lut[s1_max_r][s1_spr_r];
      s2_max_r <= s1_max_r;
      s2_sec_r <= s1_sec_r;
    end
  end

  // stage 3: raw hue with wrap
  logic signed [rgbhsl_pkg::FIELD_W-1:0] rp_s, gp_s, bp_s, hsum, hwrap;
  logic [rgbhsl_pkg::HRAW_W-1:0]         s3_hraw_r;
  rgbhsl_pkg::field_t                    s3_sat_r;
  rgbhsl_pkg::nib_t                      s3_max_r;

  always_comb begin
    rp_s = $signed({{(rgbhsl_pkg::FIELD_W - rgbhsl_pkg::PART_W){1'b0}}, s2_rp_r});
    gp_s = $signed({{(rgbhsl_pkg::FIELD_W - rgbhsl_pkg::PART_W){1'b0}}, s2_gp_r});
    bp_s = $signed({{(rgbhsl_pkg::FIELD_W - rgbhsl_pkg::PART_W){1'b0}}, s2_bp_r});
    case (s2_sec_r)
      rgbhsl_pkg::SEC_RED:   hsum = bp_s - gp_s;
      rgbhsl_pkg::SEC_GREEN: hsum = rgbhsl_pkg::HUE_OFF_GRN + rp_s - bp_s;
      rgbhsl_pkg::SEC_BLUE:  hsum = rgbhsl_pkg::HUE_OFF_BLU + gp_s - rp_s;
      default:               hsum = '0;
    endcase
    hwrap = (hsum < 0) ? hsum + rgbhsl_pkg::HUE_WRAP : hsum;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_hraw_r <= hwrap[rgbhsl_pkg::HRAW_W-1:0];
      s3_sat_r  <= s2_sat_r;
      s3_max_r  <= s2_max_r;
    end
  end

  // stage 4: scale by 2667
  logic [rgbhsl_pkg::PROD_W-1:0] s4_prod_nxt, s4_prod_r;
  rgbhsl_pkg::field_t            s4_sat_r;
  rgbhsl_pkg::nib_t              s4_max_r;

  assign s4_prod_nxt = rgbhsl_pkg::PROD_W'(s3_hraw_r) * rgbhsl_pkg::HUE_SCALE;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_prod_r <= s4_prod_nxt;
      s4_sat_r  <= s3_sat_r;
      s4_max_r  <= s3_max_r;
    end
  end

  // stage 5: divide by 1000 via reciprocal
  localparam int QW = rgbhsl_pkg::PROD_W + rgbhsl_pkg::RECIP_W;
  logic [QW-1:0]      recip_prod;
  rgbhsl_pkg::field_t s5_hue_r, s5_sat_r;
  rgbhsl_pkg::nib_t   s5_max_r;

  assign recip_prod = QW'(s4_prod_r) * QW'(rgbhsl_pkg::HUE_RECIP);

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_hue_r <= recip_prod[rgbhsl_pkg::RECIP_SH +: rgbhsl_pkg::FIELD_W];
      s5_sat_r <= s4_sat_r;
      s5_max_r <= s4_max_r;
    end
  end

  assign out_chan.valid      = s5_v_r;
  assign out_chan.hue        = s5_hue_r;
  assign out_chan.saturation = s5_sat_r;
  assign out_chan.luminance  = {s5_max_r, s5_max_r, s5_max_r, 4'b0000};

  `RGBHSL_CHK_RST(a_rst_empty, !rst_n |=> !s1_v_r && !s5_v_r, "pipeline not empty after reset")
  `RGBHSL_CHK(a_stall_hold, s4_v_r && s5_v_r && !out_chan.ready |=> s4_v_r && s5_v_r, "word lost in stall")
  `RGBHSL_CHK(a_black_zero, out_chan.valid && out_chan.luminance == '0 |-> out_chan.saturation == '0 && out_chan.hue == '0, "black gives nonzero sat or hue")
  `RGBHSL_CHK(a_grey_hue, out_chan.valid && out_chan.saturation == '0 |-> out_chan.hue == '0, "grey gives nonzero hue")

endmodule

/* sim/rgb444_to_hue_sat_lum_chk.sv */
// checker for the rgb444 to hue/sat/lum converter: predicts every accepted color word
// and compares each result word against the oldest prediction
// depends on rgbhsl_pkg, rgbhsl_in_if and rgbhsl_out_if
module rgb444_to_hue_sat_lum_chk (
  input  logic         clk,
  input  logic         rst_n,
  rgbhsl_in_if         in_chan,
  rgbhsl_out_if        out_chan,
  output int           mismatch_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rgbhsl_pkg::field_t hue;
    rgbhsl_pkg::field_t saturation;
    rgbhsl_pkg::field_t luminance;
  } hsl_word_t;

  hsl_word_t expected_hsl_q[$];
  int        fail_cnt = 0;

  function automatic logic [31:0] widen(rgbhsl_pkg::nib_t n);
    return 32'(n) * 32'h111;
  endfunction

  function automatic int hue_part(logic [31:0] mx, logic [31:0] chan, logic [31:0] spread);
    return int'((((mx - chan) << 16) / spread) >> 4);
  endfunction

  function automatic hsl_word_t predict_hsl(rgbhsl_pkg::color_t c);
    logic [31:0]          r, g, b, mx, mn, spread, sat;
    int                   rp, gp, bp, h;
    rgbhsl_pkg::hue_sec_t sec;
    hsl_word_t            w;
    r  = widen(c[2*rgbhsl_pkg::NIB_W +: rgbhsl_pkg::NIB_W]);
    g  = widen(c[rgbhsl_pkg::NIB_W +: rgbhsl_pkg::NIB_W]);
    b  = widen(c[0 +: rgbhsl_pkg::NIB_W]);
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    spread = mx - mn;
    sat = (mx != 0) ? (spread << 16) / mx : 32'd0;
    if (sat > rgbhsl_pkg::SAT_LIMIT) sat = rgbhsl_pkg::SAT_LIMIT;
    h = 0;
    if (sat != 0 && spread != 0) begin
      rp  = hue_part(mx, r, spread);
      gp  = hue_part(mx, g, spread);
      bp  = hue_part(mx, b, spread);
      sec = (r == mx) ? rgbhsl_pkg::SEC_RED :
            (g == mx) ? rgbhsl_pkg::SEC_GREEN : rgbhsl_pkg::SEC_BLUE;
      case (sec)
        rgbhsl_pkg::SEC_RED:   h = bp - gp;
        rgbhsl_pkg::SEC_GREEN: h = int'(rgbhsl_pkg::HUE_OFF_GRN) + rp - bp;
        default:               h = int'(rgbhsl_pkg::HUE_OFF_BLU) + gp - rp;
      endcase
      if (h < 0) h += int'(rgbhsl_pkg::HUE_WRAP);
      if (h < 0) h = 0;
      h = (h * int'(rgbhsl_pkg::HUE_SCALE)) / 1000;
    end
    w.hue        = rgbhsl_pkg::field_t'(h);
    w.saturation = rgbhsl_pkg::field_t'(sat);
    w.luminance  = rgbhsl_pkg::field_t'(mx << 4);
    return w;
  endfunction

  always @(posedge clk) begin
    hsl_word_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_hsl_q.size() == 0) begin
          $error("result word with nothing expected: hue %h sat %h lum %h",
                 out_chan.hue, out_chan.saturation, out_chan.luminance);
          fail_cnt++;
        end else begin
          want = expected_hsl_q.pop_front();
          if (out_chan.hue !== want.hue) begin
            $error("hue: expected %h, got %h", want.hue, out_chan.hue);
            fail_cnt++;
          end
          if (out_chan.saturation !== want.saturation) begin
            $error("saturation: expected %h, got %h", want.saturation, out_chan.saturation);
            fail_cnt++;
          end
          if (out_chan.luminance !== want.luminance) begin
            $error("luminance: expected %h, got %h", want.luminance, out_chan.luminance);
            fail_cnt++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready)
        expected_hsl_q.push_back(predict_hsl(in_chan.packed_color));
    end
    mismatch_count <= fail_cnt;
    pending        <= expected_hsl_q.size();
  end

endmodule

/* sim/rgb444_to_hue_sat_lum_tb.sv */
// top of the rgb444 to hue/sat/lum testbench: clock, reset, color stimulus,
// result back-pressure, watchdog and verdict
// depends on rgbhsl_pkg, both channel interfaces, the block and rgb444_to_hue_sat_lum_chk
module rgb444_to_hue_sat_lum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS   = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 6;

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;
  int   mismatch_count;
  int   pending;
  int   idle_cycles = 0;

  rgbhsl_in_if  in_chan ();
  rgbhsl_out_if out_chan ();

  rgb444_to_hue_sat_lum u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rgb444_to_hue_sat_lum_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb444_to_hue_sat_lum_tb NOT OK");
      $finish;
    end
  end

  task automatic send_color(input rgbhsl_pkg::color_t c);
    @(negedge clk);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.packed_color <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // black, white, primaries, greys, ties between maxima, wrapped hues
  rgbhsl_pkg::color_t corner_colors[] = '{
    12'h000, 12'hFFF, 12'hF00, 12'h0F0, 12'h00F, 12'h888, 12'h111,
    12'hFF0, 12'h0FF, 12'hF0F, 12'hF01, 12'hF10, 12'h1F0, 12'h0F1,
    12'h10F, 12'h01F, 12'hFEE, 12'hEFE, 12'hEEF, 12'h100, 12'h123,
    12'h321, 12'h5A3, 12'hC7E
  };

  initial begin
    rst_n                = 1'b0;
    no_idle              = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.packed_color = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (corner_colors[i]) send_color(corner_colors[i]);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = (n >= 1000 && n < 1400);
      send_color(rgbhsl_pkg::color_t'($urandom_range(4095, 0)));
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_chan.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("rgb444_to_hue_sat_lum_tb OK");
    end else begin
      $display("rgb444_to_hue_sat_lum_tb NOT OK");
    end
    $finish;
  end

endmodule
